[rtl/gda_pkg.sv]
`timescale 1ns / 1ps

package gda_pkg;

  // field widths of the date words
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned ResW    = 9;

  // calendar constants
  localparam int unsigned YearMod    = 400;
  localparam int unsigned CenturyLen = 100;
  localparam int unsigned MonthsPerYr = 12;
  localparam int unsigned RedSteps   = 6;
  localparam int unsigned StepW      = 3;

  localparam logic [MonthW-1:0] MonJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonDec = MonthW'(MonthsPerYr);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } gda_state_e;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             reduce;
    logic [StepW-1:0] shift;
    logic             check;
    logic             walk;
    logic             out_load;
  } gda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic walk_done;
    logic out_free;
  } gda_sts_t;

  // leap test on the year taken modulo 400
  function automatic logic gda_is_leap(input logic [ResW-1:0] res);
    logic by4;
    logic cent;
    by4  = (res[1:0] == 2'd0);
    cent = (res == ResW'(CenturyLen)) || (res == ResW'(2 * CenturyLen)) ||
           (res == ResW'(3 * CenturyLen));
    return by4 && !cent;
  endfunction

  // days in a month; anything outside 1..12 falls on the february arm
  function automatic logic [DayW-1:0] gda_month_len(input logic [MonthW-1:0] mon,
                                                    input logic leap);
    logic [DayW-1:0] len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DayW'(30);
      default:                                    len = leap ? DayW'(29) : DayW'(28);
    endcase
    return len;
  endfunction

endpackage

[rtl/gda_in_if.sv]
`timescale 1ns / 1ps

interface gda_in_if #(
  parameter int unsigned ADD_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [4:0]          day;
  logic [3:0]          month;
  logic [13:0]         year;
  logic [ADD_BITS-1:0] days_to_add;

  modport source (output valid, day, month, year, days_to_add, input ready);
  modport sink   (input valid, day, month, year, days_to_add, output ready);
endinterface

[rtl/gda_out_if.sv]
`timescale 1ns / 1ps

interface gda_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  new_day;
  logic [3:0]  new_month;
  logic [13:0] new_year;
  logic        bad_input;

  modport source (output valid, new_day, new_month, new_year, bad_input, input ready);
  modport sink   (input valid, new_day, new_month, new_year, bad_input, output ready);
endinterface

[rtl/gda_ctrl.sv]
`timescale 1ns / 1ps

module gda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gda_pkg::gda_sts_t sts_i,
  output gda_pkg::gda_cmd_t cmd_o
);
  import gda_pkg::*;

  gda_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = StepW'(RedSteps - 1);
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        cmd_o.shift  = step_q;
        if (step_q == '0) begin
          state_d = ST_CHECK;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/gda_datapath.sv]
`timescale 1ns / 1ps

module gda_datapath #(
  parameter int unsigned ADD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gda_pkg::gda_cmd_t             cmd_i,
  output gda_pkg::gda_sts_t             sts_o,
  input  logic [gda_pkg::DayW-1:0]      day_i,
  input  logic [gda_pkg::MonthW-1:0]    month_i,
  input  logic [gda_pkg::YearW-1:0]     year_i,
  input  logic [ADD_BITS-1:0]           days_to_add_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gda_pkg::DayW-1:0]      new_day_o,
  output logic [gda_pkg::MonthW-1:0]    new_month_o,
  output logic [gda_pkg::YearW-1:0]     new_year_o,
  output logic                          bad_input_o
);
  import gda_pkg::*;

  // day accumulator holds day + count; year counter holds the start year plus the walk
  localparam int unsigned AccW    = ADD_BITS + 1;
  localparam int unsigned YearMax = (2 ** YearW) + ((2 ** ADD_BITS) + 31) / 365 + 1;
  localparam int unsigned YcW     = $clog2(YearMax + 1);

  logic [AccW-1:0]     day_q;
  logic [MonthW-1:0]   month_q;
  logic [YcW-1:0]      year_q;
  logic [YearW-1:0]    res_q;
  logic [ADD_BITS-1:0] add_q;
  logic                bad_q;
  logic                out_valid_q;
  logic [DayW-1:0]     new_day_q;
  logic [MonthW-1:0]   new_month_q;
  logic [YearW-1:0]    new_year_q;
  logic                bad_input_q;

  logic                leap;
  logic [DayW-1:0]     mlen;
  logic [AccW-1:0]     mlen_ext;
  logic                bad;
  logic [YearW:0]      sub_val;
  logic [YearW:0]      res_ext;

  // month length and input check
  always_comb begin
    leap     = gda_is_leap(res_q[ResW-1:0]);
    mlen     = gda_month_len(month_q, leap);
    mlen_ext = AccW'(mlen);
    bad      = (month_q == '0) || (month_q > MonDec) || (day_q == '0) ||
               (day_q > mlen_ext);
    sub_val  = (YearW + 1)'(YearMod) << cmd_i.shift;
    res_ext  = {1'b0, res_q};
  end

  assign sts_o.bad       = bad;
  assign sts_o.walk_done = (day_q <= mlen_ext);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // working registers: load, year mod 400 by shifted subtracts, check, month walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q   <= AccW'(day_i);
      month_q <= month_i;
      year_q  <= YcW'(year_i);
      res_q   <= year_i;
      add_q   <= days_to_add_i;
    end else if (cmd_i.reduce) begin
      if (res_ext >= sub_val) begin
        res_q <= YearW'(res_ext - sub_val);
      end
    end else if (cmd_i.check) begin
      bad_q <= bad;
      if (!bad) begin
        day_q <= day_q + AccW'(add_q);
      end
    end else if (cmd_i.walk) begin
      day_q <= day_q - mlen_ext;
      if (month_q == MonDec) begin
        month_q <= MonJan;
        year_q  <= year_q + YcW'(1);
        res_q   <= (res_q == YearW'(YearMod - 1)) ? '0 : res_q + YearW'(1);
      end else begin
        month_q <= month_q + MonthW'(1);
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      new_day_q   <= day_q[DayW-1:0];
      new_month_q <= month_q;
      new_year_q  <= year_q[YearW-1:0];
      bad_input_q <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_day_o   = new_day_q;
  assign new_month_o = new_month_q;
  assign new_year_o  = new_year_q;
  assign bad_input_o = bad_input_q;

`ifndef SYNTHESIS
  // residue stays reduced while walking
  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (res_q < YearW'(YearMod)))
    else $error("year residue not below 400 during walk");

  // a walk step only happens while the day does not fit the month
  a_walk_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (day_q > mlen_ext))
    else $error("walk step with day already in month");

  // walk keeps the month legal
  a_month_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |=> (month_q >= MonJan && month_q <= MonDec))
    else $error("month out of range after walk step");

  // a word is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");
`endif

endmodule

[rtl/gregorian_date_add_days.sv]
`timescale 1ns / 1ps

// channel  modport  payload                                   handshake
// in_i     sink     day, month, year, days_to_add             valid/ready
// out_o    source   new_day, new_month, new_year, bad_input   valid/ready
//
// one word at a time: the accept state, year mod 400 by shifted subtracts, the check,
// a walk step per month crossed, a last step to see the walk end, then the output load
// rst_ni clears the controller and the output valid flag
// the next word is taken while the last result still waits on out_o; a finished
// word then holds in the done state until out_o frees up, and the input stalls
module gregorian_date_add_days #(
  parameter int unsigned ADD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gda_in_if.sink    in_i,
  gda_out_if.source out_o
);
  import gda_pkg::*;

  gda_cmd_t cmd;
  gda_sts_t sts;

  gda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gda_datapath #(
    .ADD_BITS (ADD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .day_i         (in_i.day),
    .month_i       (in_i.month),
    .year_i        (in_i.year),
    .days_to_add_i (in_i.days_to_add),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .new_day_o     (out_o.new_day),
    .new_month_o   (out_o.new_month),
    .new_year_o    (out_o.new_year),
    .bad_input_o   (out_o.bad_input)
  );

endmodule
